>>> hdl/cpb_pkg.sv
// package with constants, types and register codes of the clipped pattern blitter
package cpb_pkg;

  localparam int FRAME_WIDTH     = 320;
  localparam int FRAME_HEIGHT    = 240;
  localparam int MAX_PATTERN_DIM = 512;

  localparam int ORG_W      = 11;
  localparam int DIM_W      = 10;
  localparam int COLOR_W    = 16;
  localparam int ADDR_W     = 17;
  localparam int CNT_W      = $clog2(MAX_PATTERN_DIM);
  localparam int COORD_W    = ORG_W + 1;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [COLOR_W-1:0] TRANSPARENT_COLOR = 16'hFFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ORIGIN_X   = 3'd0,
    CFG_ORIGIN_Y   = 3'd1,
    CFG_WIDTH      = 3'd2,
    CFG_HEIGHT     = 3'd3,
    CFG_FG_COLOR   = 3'd4,
    CFG_BG_COLOR   = 3'd5,
    CFG_FILL_MODE  = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [ORG_W-1:0]   origin_x;
    logic [ORG_W-1:0]   origin_y;
    logic [DIM_W-1:0]   pattern_width;
    logic [DIM_W-1:0]   pattern_height;
    logic [COLOR_W-1:0] fg_color;
    logic [COLOR_W-1:0] bg_color;
    logic               fill_mode;
  } cfg_t;

  typedef struct packed {
    logic               write_enable;
    logic [ADDR_W-1:0]  pixel_address;
    logic [COLOR_W-1:0] pixel_color;
    logic               pattern_done;
  } pix_t;

  typedef struct packed {
    logic last_col;
    logic last_row;
  } step_t;

endpackage

>>> hdl/cpb_in_if.sv
// pattern bit channel
interface cpb_in_if;
  logic valid;
  logic ready;
  logic pattern_bit;

  modport source (output valid, output pattern_bit, input ready);
  modport sink (input valid, input pattern_bit, output ready);
endinterface

>>> hdl/cpb_out_if.sv
// pixel write channel
interface cpb_out_if import cpb_pkg::*;;
  logic               valid;
  logic               ready;
  logic               write_enable;
  logic [ADDR_W-1:0]  pixel_address;
  logic [COLOR_W-1:0] pixel_color;
  logic               pattern_done;

  modport source (output valid, output write_enable, output pixel_address,
                  output pixel_color, output pattern_done, input ready);
  modport sink (input valid, input write_enable, input pixel_address,
                input pixel_color, input pattern_done, output ready);
endinterface

>>> hdl/cpb_pixel_calc.sv
// screen position, clipping, color select and pattern step decode for one word
module cpb_pixel_calc import cpb_pkg::*; (
  input  cfg_t             cfg_i,
  input  logic [CNT_W-1:0] col_i,
  input  logic [CNT_W-1:0] row_i,
  input  logic             pattern_bit_i,
  output pix_t             pix_o,
  output step_t            step_o
);

  logic [DIM_W-1:0]          w_clamp;
  logic [DIM_W-1:0]          h_clamp;
  logic signed [COORD_W-1:0] x;
  logic signed [COORD_W-1:0] y;
  logic                      on_screen;
  logic                      set;
  logic                      we;
  logic [ADDR_W-1:0]         addr;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
    if (d == '0) begin
      return DIM_W'(1);
    end else if (d > DIM_W'(MAX_PATTERN_DIM)) begin
      return DIM_W'(MAX_PATTERN_DIM);
    end
    return d;
  endfunction

  always_comb begin
    w_clamp   = clamp_dim(cfg_i.pattern_width);
    h_clamp   = clamp_dim(cfg_i.pattern_height);
    x         = COORD_W'($signed(cfg_i.origin_x)) + $signed({3'b000, col_i});
    y         = COORD_W'($signed(cfg_i.origin_y)) + $signed({3'b000, row_i});
    on_screen = (x >= 0) && (x < COORD_W'(FRAME_WIDTH))
             && (y >= 0) && (y < COORD_W'(FRAME_HEIGHT));
    set       = pattern_bit_i | cfg_i.fill_mode;
    we        = on_screen && (set || (cfg_i.bg_color != TRANSPARENT_COLOR));
    // times frame width is a constant multiply: shifts and adds
    addr      = ADDR_W'(ADDR_W'(unsigned'(y)) * ADDR_W'(FRAME_WIDTH)
                        + ADDR_W'(unsigned'(x)));

    step_o.last_col = (DIM_W'(col_i) + DIM_W'(1)) >= w_clamp;
    step_o.last_row = (DIM_W'(row_i) + DIM_W'(1)) >= h_clamp;

    pix_o.write_enable  = we;
    pix_o.pixel_address = we ? addr : '0;
    pix_o.pixel_color   = we ? (set ? cfg_i.fg_color : cfg_i.bg_color) : '0;
    pix_o.pattern_done  = step_o.last_col & step_o.last_row;
  end

endmodule

>>> hdl/clipped_pattern_blitter.sv
// clipped monochrome pattern blitter top level
// a pattern bit taken at a clock edge is shown on the pixel port after that edge,
// unless the pixel port stalls; it then waits in the skid register
// throughput: one pattern bit per cycle, held up only by the pixel port;
// a two-entry output stage (output register plus skid) keeps ready registered
// reset: registers return to origin 0,0, size 1x1, colors 0xffff, fill off,
// counters to zero, no word pending
module clipped_pattern_blitter import cpb_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  cpb_in_if.sink                pat_i,
  cpb_out_if.source             pix_o
);

  cfg_t             cfg_q, cfg_d;
  logic [CNT_W-1:0] col_q, col_d;
  logic [CNT_W-1:0] row_q, row_d;
  pix_t             out_q, out_d;
  pix_t             skid_q, skid_d;
  logic             out_valid_q, out_valid_d;
  logic             skid_valid_q, skid_valid_d;
  pix_t             res;
  step_t            step;
  logic             accept;
  logic             take;

  cpb_pixel_calc u_calc (
    .cfg_i        (cfg_q),
    .col_i        (col_q),
    .row_i        (row_q),
    .pattern_bit_i(pat_i.pattern_bit),
    .pix_o        (res),
    .step_o       (step)
  );

  assign pat_i.ready = ~skid_valid_q;
  assign accept      = pat_i.valid & pat_i.ready;
  assign take        = pix_o.valid & pix_o.ready;

  assign pix_o.valid         = out_valid_q;
  assign pix_o.write_enable  = out_q.write_enable;
  assign pix_o.pixel_address = out_q.pixel_address;
  assign pix_o.pixel_color   = out_q.pixel_color;
  assign pix_o.pattern_done  = out_q.pattern_done;

  // register writes
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_ORIGIN_X:  cfg_d.origin_x       = cfg_data_i[ORG_W-1:0];
        CFG_ORIGIN_Y:  cfg_d.origin_y       = cfg_data_i[ORG_W-1:0];
        CFG_WIDTH:     cfg_d.pattern_width  = cfg_data_i[DIM_W-1:0];
        CFG_HEIGHT:    cfg_d.pattern_height = cfg_data_i[DIM_W-1:0];
        CFG_FG_COLOR:  cfg_d.fg_color       = cfg_data_i[COLOR_W-1:0];
        CFG_BG_COLOR:  cfg_d.bg_color       = cfg_data_i[COLOR_W-1:0];
        CFG_FILL_MODE: cfg_d.fill_mode      = cfg_data_i[0];
        default:       cfg_d                = cfg_q;
      endcase
    end
  end

  // column and row counters
  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (accept) begin
      if (step.last_col) begin
        col_d = '0;
        row_d = step.last_row ? '0 : row_q + CNT_W'(1);
      end else begin
        col_d = col_q + CNT_W'(1);
      end
    end
  end

  // output register and skid
  always_comb begin
    out_d        = out_q;
    skid_d       = skid_q;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (take || !out_valid_q) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end else begin
        out_d       = res;
        out_valid_d = accept;
      end
    end else if (accept) begin
      skid_d       = res;
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.origin_x       <= '0;
      cfg_q.origin_y       <= '0;
      cfg_q.pattern_width  <= DIM_W'(1);
      cfg_q.pattern_height <= DIM_W'(1);
      cfg_q.fg_color       <= TRANSPARENT_COLOR;
      cfg_q.bg_color       <= TRANSPARENT_COLOR;
      cfg_q.fill_mode      <= 1'b0;
      col_q                <= '0;
      row_q                <= '0;
      out_valid_q          <= 1'b0;
      skid_valid_q         <= 1'b0;
    end else begin
      cfg_q        <= cfg_d;
      col_q        <= col_d;
      row_q        <= row_d;
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

endmodule
